### sv/mmcb_pkg.sv
// ----------------------------------------------------------------------------
// mmcb_pkg
// Types, register indexes and depth codes shared by the mask expansion blit.
// ----------------------------------------------------------------------------
package mmcb_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned BIR_W     = 10;
  localparam int unsigned PER_ROW_W = 11;
  localparam int unsigned MAX_WIDTH = 4096;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
  typedef logic [23:0]          color_t;
  typedef logic [31:0]          addr_t;
  typedef logic [31:0]          pixel_t;

  localparam cfg_idx_t CFG_DEPTH_MODE   = 3'd0;
  localparam cfg_idx_t CFG_BASE_ADDRESS = 3'd1;
  localparam cfg_idx_t CFG_ROW_PITCH    = 3'd2;
  localparam cfg_idx_t CFG_WIDTH_PIXELS = 3'd3;
  localparam cfg_idx_t CFG_FG_INDEX     = 3'd4;
  localparam cfg_idx_t CFG_BG_INDEX     = 3'd5;

  localparam logic [2:0] DEPTH_8  = 3'd0;
  localparam logic [2:0] DEPTH_15 = 3'd1;
  localparam logic [2:0] DEPTH_16 = 3'd2;
  localparam logic [2:0] DEPTH_24 = 3'd3;
  localparam logic [2:0] DEPTH_32 = 3'd4;

  localparam logic       KIND_PALETTE = 1'b0;
  localparam logic       KIND_MASK    = 1'b1;

  // Packs a 24-bit RGB color into RGB555.
  function automatic logic [15:0] pack_rgb555(input color_t c);
    logic [15:0] r;
    r = {1'b0, c[23:19], c[15:11], c[7:3]};
    return r;
  endfunction

endpackage

### sv/mmcb_in_if.sv
// ----------------------------------------------------------------------------
// mmcb_in_if
// Input channel: palette writes and mask bytes.
// ----------------------------------------------------------------------------
interface mmcb_in_if;
  import mmcb_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  logic   [7:0] pal_index;
  color_t pal_color;
  logic   [7:0] mask_bits;
  logic   start_req;

  modport source (output valid, kind, pal_index, pal_color, mask_bits, start_req,
                  input ready);
  modport sink   (input valid, kind, pal_index, pal_color, mask_bits, start_req,
                  output ready);
endinterface

### sv/mmcb_out_if.sv
// ----------------------------------------------------------------------------
// mmcb_out_if
// Result channel: one frame buffer pixel write per beat.
// ----------------------------------------------------------------------------
interface mmcb_out_if;
  import mmcb_pkg::*;

  logic   valid;
  logic   ready;
  addr_t  address;
  pixel_t data;
  logic   [2:0] write_bytes;
  logic   last;

  modport source (output valid, address, data, write_bytes, last, input ready);
  modport sink   (input valid, address, data, write_bytes, last, output ready);
endinterface

### sv/mmcb_cfg_if.sv
// ----------------------------------------------------------------------------
// mmcb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mmcb_cfg_if;
  import mmcb_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/mono_mask_color_expand_blit.sv
// ----------------------------------------------------------------------------
// mono_mask_color_expand_blit
// Expands mask bytes into pixel writes using a palette held in block RAM.
// ----------------------------------------------------------------------------
// A palette-write beat stores one color and produces no output. A mask-byte
// beat produces eight pixel-write beats, leftmost pixel first, one per cycle
// while the sink is ready; the single output stage emitting one write per
// cycle sets that rate. The foreground and background entries are read from
// the palette RAM into registers when the mask byte is accepted, and a second
// mask byte is taken into a holding stage while the first is still being
// emitted, so back-to-back mask bytes flow without gaps. Palette writes are
// accepted at one per cycle unless a mask byte is waiting in the holding
// stage. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module mono_mask_color_expand_blit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input logic clk,
  input logic rst_n,
  mmcb_in_if.sink    in_ch,
  mmcb_out_if.source out_ch,
  mmcb_cfg_if.sink   cfg_ch
);
  import mmcb_pkg::*;

  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Configuration registers.
  logic [2:0]  depth_mode_r;
  addr_t       base_address_r;
  logic [15:0] row_pitch_r;
  logic [12:0] width_pixels_r;
  logic [7:0]  fg_index_r;
  logic [7:0]  bg_index_r;

  // Palette RAM.
  color_t pal_mem [PALETTE_ENTRIES];

  // Holding stage: one accepted mask byte with its palette reads.
  logic   s1_valid_r;
  logic   [7:0] s1_mask_r;
  logic   s1_start_r;
  color_t fg_rd_r;
  color_t bg_rd_r;

  // Output stage.
  logic   s2_valid_r;
  logic   [2:0] cnt_r;
  logic   [7:0] mask_r;
  pixel_t fg_pix_r;
  pixel_t bg_pix_r;
  addr_t  addr_r;
  logic   [2:0] wbytes_r;
  logic   [2:0] step_r;

  // Blit position.
  addr_t  wp_r;
  addr_t  rs_r;
  logic   [BIR_W-1:0] bir_r;

  logic in_fire, out_fire, last_beat, s2_load;
  logic fg_ok, bg_ok;

  assign fg_ok = {1'b0, fg_index_r} < 9'(PALETTE_ENTRIES);
  assign bg_ok = {1'b0, bg_index_r} < 9'(PALETTE_ENTRIES);

  assign last_beat = (cnt_r == 3'd7);
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign s2_load   = s1_valid_r && (!s2_valid_r || (out_ch.ready && last_beat));
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = s2_valid_r;
  assign out_ch.address     = addr_r;
  assign out_ch.data        = mask_r[7] ? fg_pix_r : bg_pix_r;
  assign out_ch.write_bytes = wbytes_r;
  assign out_ch.last        = last_beat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r   <= DEPTH_8;
      base_address_r <= '0;
      row_pitch_r    <= '0;
      width_pixels_r <= 13'd8;
      fg_index_r     <= '0;
      bg_index_r     <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_DEPTH_MODE:   depth_mode_r   <= cfg_ch.data[2:0];
        CFG_BASE_ADDRESS: base_address_r <= cfg_ch.data;
        CFG_ROW_PITCH:    row_pitch_r    <= cfg_ch.data[15:0];
        CFG_WIDTH_PIXELS: width_pixels_r <= cfg_ch.data[12:0];
        CFG_FG_INDEX:     fg_index_r     <= cfg_ch.data[7:0];
        CFG_BG_INDEX:     bg_index_r     <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Palette RAM: writes come from palette beats, reads from mask beats, so
  // the two never fall on the same edge and a read always sees prior writes.
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.kind == KIND_PALETTE) &&
        ({1'b0, in_ch.pal_index} < 9'(PALETTE_ENTRIES))) begin
      pal_mem[in_ch.pal_index[PAL_AW-1:0]] <= in_ch.pal_color;
    end
    if (in_fire && (in_ch.kind == KIND_MASK)) begin
      fg_rd_r <= pal_mem[fg_index_r[PAL_AW-1:0]];
      bg_rd_r <= pal_mem[bg_index_r[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire && (in_ch.kind == KIND_MASK)) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.kind == KIND_MASK)) begin
      s1_mask_r  <= in_ch.mask_bits;
      s1_start_r <= in_ch.start_req;
    end
  end

  // Pixel values, write size and address step for the current depth.
  pixel_t     fg_pix_nxt, bg_pix_nxt;
  logic [2:0] wbytes_nxt, step_nxt;

  always_comb begin
    unique case (depth_mode_r)
      DEPTH_15: begin
        wbytes_nxt = 3'd2;
        step_nxt   = 3'd2;
        fg_pix_nxt = fg_ok ? {16'b0, pack_rgb555(fg_rd_r)} : '0;
        bg_pix_nxt = bg_ok ? {16'b0, pack_rgb555(bg_rd_r)} : '0;
      end
      DEPTH_16: begin
        wbytes_nxt = 3'd2;
        step_nxt   = 3'd2;
        fg_pix_nxt = '0;
        bg_pix_nxt = '0;
      end
      DEPTH_24, DEPTH_32: begin
        wbytes_nxt = 3'd4;
        step_nxt   = (depth_mode_r == DEPTH_24) ? 3'd3 : 3'd4;
        fg_pix_nxt = fg_ok ? {8'b0, fg_rd_r} : '0;
        bg_pix_nxt = bg_ok ? {8'b0, bg_rd_r} : '0;
      end
      default: begin
        // Depth 8 and the unused codes pass the index straight through.
        wbytes_nxt = 3'd1;
        step_nxt   = 3'd1;
        fg_pix_nxt = {24'b0, fg_index_r};
        bg_pix_nxt = {24'b0, bg_index_r};
      end
    endcase
  end

  // Row bookkeeping for the byte being loaded into the output stage.
  logic [12:0]          w_clamp;
  logic [PER_ROW_W-1:0] per_row;
  logic [13:0]          w_sum;
  addr_t                p0, rs0, wp_nxt, rs_nxt;
  logic [BIR_W-1:0]     bir0, bir_nxt;
  logic [PER_ROW_W-1:0] bir_inc;
  logic                 row_end;

  always_comb begin
    w_clamp = ({1'b0, width_pixels_r} > 14'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_pixels_r;
    w_sum   = {1'b0, w_clamp} + 14'd7;
    per_row = w_sum[13:3];
    if (per_row == '0) begin
      per_row = PER_ROW_W'(1);
    end
    p0      = s1_start_r ? base_address_r : wp_r;
    rs0     = s1_start_r ? base_address_r : rs_r;
    bir0    = s1_start_r ? '0 : bir_r;
    bir_inc = {1'b0, bir0} + PER_ROW_W'(1);
    row_end = (bir_inc >= per_row);
    if (row_end) begin
      rs_nxt  = rs0 + {16'b0, row_pitch_r};
      wp_nxt  = rs_nxt;
      bir_nxt = '0;
    end else begin
      rs_nxt  = rs0;
      wp_nxt  = p0 + {26'b0, step_nxt, 3'b0};
      bir_nxt = bir_inc[BIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rs_r  <= '0;
      bir_r <= '0;
    end else if (s2_load) begin
      wp_r  <= wp_nxt;
      rs_r  <= rs_nxt;
      bir_r <= bir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
      cnt_r      <= '0;
    end else if (out_fire) begin
      if (last_beat) begin
        s2_valid_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      mask_r   <= s1_mask_r;
      fg_pix_r <= fg_pix_nxt;
      bg_pix_r <= bg_pix_nxt;
      addr_r   <= p0;
      wbytes_r <= wbytes_nxt;
      step_r   <= step_nxt;
    end else if (out_fire) begin
      mask_r <= {mask_r[6:0], 1'b0};
      addr_r <= addr_r + {29'b0, step_r};
    end
  end

endmodule
